// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the disc shader design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define SDPS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define SDPS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`else

`define SDPS_ASSERT(lbl, clk, rstn, prop, msg)

`define SDPS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== design/sdps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdps_pkg
// Types, constants and shading tables of the supersampled disc pixel shader.
// ----------------------------------------------------------------------------
package sdps_pkg;

  localparam int unsigned ImageRows = 640;
  localparam int unsigned ImageCols = 480;

  localparam int unsigned RowW     = 10;
  localparam int unsigned ColW     = 9;
  localparam int unsigned CoordW   = 16;
  localparam int unsigned RadW     = 15;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned RedW     = 7;
  localparam int unsigned GreenW   = 7;
  localparam int unsigned BlueW    = 8;

  localparam int unsigned NumBodies  = 3;
  localparam int unsigned GridN      = 5;
  localparam int unsigned GridHalf   = GridN / 2;
  localparam int unsigned NumSamples = GridN * GridN;
  localparam int unsigned PixMul     = GridN;
  localparam int unsigned SubShift   = 3;

  localparam int unsigned BaseW     = 14;
  localparam int unsigned SampW     = 17;
  localparam int unsigned DiffW     = 19;
  localparam int unsigned SqW       = 2 * DiffW;
  localparam int unsigned R2W       = 2 * RadW;
  localparam int unsigned CountW    = $clog2(NumSamples + 1);
  localparam int unsigned RowCountW = $clog2(GridN + 1);

  localparam logic [CfgIdxW-1:0] RegBody0X     = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegBody0Y     = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegBody1X     = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegBody1Y     = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] RegBody2X     = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] RegBody2Y     = CfgIdxW'(5);
  localparam logic [CfgIdxW-1:0] RegDiscRadius = CfgIdxW'(6);

  localparam logic [CoordW-1:0] Body0XRst = CoordW'(880);
  localparam logic [CoordW-1:0] Body0YRst = CoordW'(800);
  localparam logic [CoordW-1:0] Body1XRst = CoordW'(-880);
  localparam logic [CoordW-1:0] Body1YRst = CoordW'(0);
  localparam logic [CoordW-1:0] Body2XRst = CoordW'(0);
  localparam logic [CoordW-1:0] Body2YRst = CoordW'(-1280);
  localparam logic [RadW-1:0]   RadiusRst = RadW'(120);

  typedef struct packed {
    logic [NumBodies-1:0][CoordW-1:0] body_x;
    logic [NumBodies-1:0][CoordW-1:0] body_y;
    logic [RadW-1:0]                  radius;
  } cfg_t;

  typedef struct packed {
    logic [RowW-1:0] pixel_row;
    logic [ColW-1:0] pixel_col;
  } pix_t;

  typedef logic [NumBodies-1:0][GridN-1:0][DiffW-1:0] diff_arr_t;
  typedef logic [NumBodies-1:0][GridN-1:0][SqW-1:0]   sq_arr_t;

  typedef struct packed {
    sq_arr_t        dx2;
    sq_arr_t        dy2;
    logic [R2W-1:0] r2;
  } sq_t;

  typedef logic [GridN-1:0][GridN-1:0] mask_t;

  typedef struct packed {
    logic [RedW-1:0]   red;
    logic [GreenW-1:0] green;
    logic [BlueW-1:0]  blue;
  } rgb_t;

  localparam logic [RedW-1:0] RedLut [NumSamples+1] = '{
    7'd0,   7'd5,   7'd10,  7'd15,  7'd20,  7'd25,  7'd30,  7'd35,  7'd40,
    7'd45,  7'd50,  7'd55,  7'd60,  7'd66,  7'd71,  7'd76,  7'd81,  7'd86,
    7'd91,  7'd96,  7'd101, 7'd106, 7'd111, 7'd116, 7'd121, 7'd127
  };

  localparam logic [BlueW-1:0] BlueLut [NumSamples+1] = '{
    8'd0,   8'd10,  8'd20,  8'd30,  8'd40,  8'd51,  8'd61,  8'd71,  8'd81,
    8'd91,  8'd102, 8'd112, 8'd122, 8'd132, 8'd142, 8'd153, 8'd163, 8'd173,
    8'd183, 8'd193, 8'd204, 8'd214, 8'd224, 8'd234, 8'd244, 8'd255
  };

  function automatic rgb_t shade(logic [CountW-1:0] k);
    rgb_t c;
    c = '0;
    if (k <= CountW'(NumSamples)) begin
      c.red   = RedLut[k];
      c.green = RedLut[k];
      c.blue  = BlueLut[k];
    end
    return c;
  endfunction

endpackage

// ===== design/sdps_pix_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdps_pix_if
// Pixel coordinate stream with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sdps_pix_if;
  logic                      valid;
  logic                      ready;
  logic [sdps_pkg::RowW-1:0] pixel_row;
  logic [sdps_pkg::ColW-1:0] pixel_col;

  modport source (output valid, output pixel_row, output pixel_col, input ready);
  modport sink   (input valid, input pixel_row, input pixel_col, output ready);
endinterface

// ===== design/sdps_rgb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdps_rgb_if
// Shaded pixel color stream with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sdps_rgb_if;
  logic                        valid;
  logic                        ready;
  logic [sdps_pkg::RedW-1:0]   red;
  logic [sdps_pkg::GreenW-1:0] green;
  logic [sdps_pkg::BlueW-1:0]  blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== design/supersampled_disc_pixel_shader_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// supersampled_disc_pixel_shader_core
// 5x5 supersampled coverage of three discs, shaded into an RGB pixel.
// ----------------------------------------------------------------------------
//   channel | dir | payload                        | accepted when
//   pix_i   | in  | pixel_row[9:0], pixel_col[8:0] | valid & ready
//   rgb_o   | out | red[6:0], green[6:0], blue[7:0] | valid & ready
//   cfg     | in  | cfg_idx_i[2:0], cfg_data_i     | cfg_we_i
//
// One pixel per cycle sustained while rgb_o.ready stays high.
// Six register stages: grid base, center offsets, squares, coverage mask,
// count, output register. Each stage holds under back-pressure and fills
// bubbles; ready is a combinational chain from rgb_o.ready.
// Reset clears all valid bits and loads the default disc set.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module supersampled_disc_pixel_shader_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sdps_pix_if.sink                      pix_i,
  sdps_rgb_if.source                    rgb_o,
  input  logic                          cfg_we_i,
  input  logic [sdps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sdps_pkg::CfgDataW-1:0] cfg_data_i
);

  sdps_pkg::cfg_t cfg_q;
  sdps_pkg::pix_t pix;
  sdps_pkg::sq_t  sq;
  sdps_pkg::rgb_t rgb_q;

  logic                        geom_vld, geom_rdy;
  logic                        cnt_vld, cnt_rdy;
  logic [sdps_pkg::CountW-1:0] cnt;
  logic                        out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.body_x[0] <= sdps_pkg::Body0XRst;
      cfg_q.body_y[0] <= sdps_pkg::Body0YRst;
      cfg_q.body_x[1] <= sdps_pkg::Body1XRst;
      cfg_q.body_y[1] <= sdps_pkg::Body1YRst;
      cfg_q.body_x[2] <= sdps_pkg::Body2XRst;
      cfg_q.body_y[2] <= sdps_pkg::Body2YRst;
      cfg_q.radius    <= sdps_pkg::RadiusRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sdps_pkg::RegBody0X:     cfg_q.body_x[0] <= cfg_data_i;
        sdps_pkg::RegBody0Y:     cfg_q.body_y[0] <= cfg_data_i;
        sdps_pkg::RegBody1X:     cfg_q.body_x[1] <= cfg_data_i;
        sdps_pkg::RegBody1Y:     cfg_q.body_y[1] <= cfg_data_i;
        sdps_pkg::RegBody2X:     cfg_q.body_x[2] <= cfg_data_i;
        sdps_pkg::RegBody2Y:     cfg_q.body_y[2] <= cfg_data_i;
        sdps_pkg::RegDiscRadius: cfg_q.radius    <= cfg_data_i[sdps_pkg::RadW-1:0];
        default: ;
      endcase
    end
  end

  assign pix.pixel_row = pix_i.pixel_row;
  assign pix.pixel_col = pix_i.pixel_col;

  sdps_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .in_pix_i    (pix),
    .cfg_i       (cfg_q),
    .out_valid_o (geom_vld),
    .out_ready_i (geom_rdy),
    .out_sq_o    (sq)
  );

  sdps_cover u_cover (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (geom_vld),
    .in_ready_o  (geom_rdy),
    .in_sq_i     (sq),
    .out_valid_o (cnt_vld),
    .out_ready_i (cnt_rdy),
    .out_count_o (cnt)
  );

  assign cnt_rdy = !out_vld_q || rgb_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cnt_rdy) begin
      out_vld_q <= cnt_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_rdy && cnt_vld) begin
      rgb_q <= sdps_pkg::shade(cnt);
    end
  end

  assign rgb_o.valid = out_vld_q;
  assign rgb_o.red   = rgb_q.red;
  assign rgb_o.green = rgb_q.green;
  assign rgb_o.blue  = rgb_q.blue;

  `SDPS_ASSERT_IMPL(a_red_eq_green, clk_i, rst_ni, rgb_o.valid, rgb_o.red == rgb_o.green, "red and green channels differ")
  `SDPS_ASSERT_IMPL(a_blue_ge_red, clk_i, rst_ni, rgb_o.valid, rgb_o.blue >= sdps_pkg::BlueW'(rgb_o.red), "blue below red")
  `SDPS_ASSERT_IMPL(a_black_consistent, clk_i, rst_ni, rgb_o.valid && rgb_o.blue == '0, rgb_o.red == '0, "blue zero with nonzero red")

endmodule

// ===== design/sdps_geom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdps_geom
// Sample grid placement, center offsets and squared distances (3 stages).
// ----------------------------------------------------------------------------
module sdps_geom (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sdps_pkg::pix_t  in_pix_i,
  input  sdps_pkg::cfg_t  cfg_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sdps_pkg::sq_t   out_sq_o
);

  logic [2:0] vld_q;
  logic [2:0] rdy;

  logic signed [sdps_pkg::BaseW-1:0] row_ofs, col_ofs;
  logic signed [sdps_pkg::BaseW-1:0] bx_d, by_d, bx_q, by_q;

  sdps_pkg::diff_arr_t          dx_d, dy_d, dx_q, dy_q;
  logic [sdps_pkg::R2W-1:0]     r2_d, r2_q;
  sdps_pkg::sq_t                sq_d, sq_q;

  assign rdy[2]     = !vld_q[2] || out_ready_i;
  assign rdy[1]     = !vld_q[1] || rdy[2];
  assign rdy[0]     = !vld_q[0] || rdy[1];
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
    end
  end

  // stage 1: pixel to sample grid center
  always_comb begin
    row_ofs = $signed(sdps_pkg::BaseW'(in_pix_i.pixel_row))
            - $signed(sdps_pkg::BaseW'(sdps_pkg::ImageRows / 2));
    col_ofs = $signed(sdps_pkg::BaseW'(in_pix_i.pixel_col))
            - $signed(sdps_pkg::BaseW'(sdps_pkg::ImageCols / 2));
    bx_d    = row_ofs * $signed(sdps_pkg::BaseW'(sdps_pkg::PixMul));
    by_d    = col_ofs * $signed(sdps_pkg::BaseW'(sdps_pkg::PixMul));
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      bx_q <= bx_d;
      by_q <= by_d;
    end
  end

  // stage 2: offsets from each body center
  always_comb begin
    logic signed [sdps_pkg::SampW-1:0] sx;
    logic signed [sdps_pkg::SampW-1:0] sy;
    for (int g = 0; g < sdps_pkg::GridN; g++) begin
      sx = (sdps_pkg::SampW'(bx_q) + sdps_pkg::SampW'(g)
          - sdps_pkg::SampW'(sdps_pkg::GridHalf)) <<< sdps_pkg::SubShift;
      sy = (sdps_pkg::SampW'(by_q) + sdps_pkg::SampW'(g)
          - sdps_pkg::SampW'(sdps_pkg::GridHalf)) <<< sdps_pkg::SubShift;
      for (int b = 0; b < sdps_pkg::NumBodies; b++) begin
        dx_d[b][g] = sdps_pkg::DiffW'(sx) - sdps_pkg::DiffW'($signed(cfg_i.body_x[b]));
        dy_d[b][g] = sdps_pkg::DiffW'(sy) - sdps_pkg::DiffW'($signed(cfg_i.body_y[b]));
      end
    end
    r2_d = sdps_pkg::R2W'(cfg_i.radius) * sdps_pkg::R2W'(cfg_i.radius);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1] && vld_q[0]) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      r2_q <= r2_d;
    end
  end

  // stage 3: squares
  always_comb begin
    logic signed [sdps_pkg::SqW-1:0] px;
    logic signed [sdps_pkg::SqW-1:0] py;
    for (int b = 0; b < sdps_pkg::NumBodies; b++) begin
      for (int g = 0; g < sdps_pkg::GridN; g++) begin
        px = $signed(dx_q[b][g]) * $signed(dx_q[b][g]);
        py = $signed(dy_q[b][g]) * $signed(dy_q[b][g]);
        sq_d.dx2[b][g] = px;
        sq_d.dy2[b][g] = py;
      end
    end
    sq_d.r2 = r2_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2] && vld_q[1]) begin
      sq_q <= sq_d;
    end
  end

  assign out_valid_o = vld_q[2];
  assign out_sq_o    = sq_q;

endmodule

// ===== design/sdps_cover.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdps_cover
// Per-sample disc coverage test and coverage count (2 stages).
// ----------------------------------------------------------------------------
module sdps_cover (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  sdps_pkg::sq_t               in_sq_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [sdps_pkg::CountW-1:0] out_count_o
);

  logic [1:0] vld_q;
  logic [1:0] rdy;

  sdps_pkg::mask_t                mask_d, mask_q;
  logic [sdps_pkg::CountW-1:0]    count_d, count_q;

  assign rdy[1]     = !vld_q[1] || out_ready_i;
  assign rdy[0]     = !vld_q[0] || rdy[1];
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
    end
  end

  // stage 4: strict inside test against every body
  always_comb begin
    logic [sdps_pkg::SqW:0] dsq;
    logic                   hit;
    for (int i = 0; i < sdps_pkg::GridN; i++) begin
      for (int j = 0; j < sdps_pkg::GridN; j++) begin
        hit = 1'b0;
        for (int b = 0; b < sdps_pkg::NumBodies; b++) begin
          dsq = (sdps_pkg::SqW + 1)'(in_sq_i.dx2[b][i])
              + (sdps_pkg::SqW + 1)'(in_sq_i.dy2[b][j]);
          if (dsq < (sdps_pkg::SqW + 1)'(in_sq_i.r2)) hit = 1'b1;
        end
        mask_d[i][j] = hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      mask_q <= mask_d;
    end
  end

  // stage 5: count covered samples, row sums first
  always_comb begin
    logic [sdps_pkg::RowCountW-1:0] rc;
    count_d = '0;
    for (int i = 0; i < sdps_pkg::GridN; i++) begin
      rc = '0;
      for (int j = 0; j < sdps_pkg::GridN; j++) begin
        rc = rc + sdps_pkg::RowCountW'(mask_q[i][j]);
      end
      count_d = count_d + sdps_pkg::CountW'(rc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1] && vld_q[0]) begin
      count_q <= count_d;
    end
  end

  assign out_valid_o = vld_q[1];
  assign out_count_o = count_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the supersampled disc pixel shader against a behavioral coverage
// counter. Pixels stream in under random source gaps and sink stalls across
// several disc settings, default, degenerate, extreme and random, and every
// shaded color is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
  import sdps_pkg::*;

  localparam int unsigned LatencyCycles = 6;
  localparam int unsigned IdleLimit     = 2000;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned NumRegs       = 7;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned PhaseItems    = 125;
  localparam int unsigned FullRateItems = 150;
  localparam logic [CfgIdxW-1:0] RegUnused = CfgIdxW'(7);

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  sdps_pix_if pix ();
  sdps_rgb_if rgb ();

  supersampled_disc_pixel_shader_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix),
    .rgb_o      (rgb),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  logic signed [CoordW-1:0] disc_x [NumBodies];
  logic signed [CoordW-1:0] disc_y [NumBodies];
  logic [RadW-1:0]          disc_r;

  rgb_t                pending_colors [$];
  rgb_t                want;
  int unsigned         pixels_sent;
  int unsigned         colors_checked;
  int unsigned         color_mismatches;
  int unsigned         idle_cycles;
  int unsigned         settings_used;
  logic [NumSamples:0] levels_seen;
  bit                  calm;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Count samples of the 5x5 grid that fall strictly inside any disc.
  function automatic int unsigned covered_samples(logic [RowW-1:0] row, logic [ColW-1:0] col);
    longint base_x;
    longint base_y;
    longint sx;
    longint sy;
    longint dx;
    longint dy;
    longint r2;
    int unsigned k;
    bit hit;
    base_x = (longint'(row) - longint'(ImageRows / 2)) * longint'(GridN);
    base_y = (longint'(col) - longint'(ImageCols / 2)) * longint'(GridN);
    r2 = longint'(disc_r) * longint'(disc_r);
    k = 0;
    for (int i = -2; i <= 2; i++) begin
      for (int j = -2; j <= 2; j++) begin
        sx = (base_x + i) * 8;
        sy = (base_y + j) * 8;
        hit = 1'b0;
        for (int b = 0; b < NumBodies; b++) begin
          dx = sx - longint'(disc_x[b]);
          dy = sy - longint'(disc_y[b]);
          if (dx * dx + dy * dy < r2) hit = 1'b1;
        end
        if (hit) k++;
      end
    end
    return k;
  endfunction

  // Pick a pixel index near a disc center on one axis, clamped to the field.
  function automatic longint aim_at(longint centre, longint origin, longint limit);
    longint reach;
    longint p;
    reach = longint'(disc_r) / 40 + 2;
    p = centre / 40 + origin + longint'($urandom_range(0, 2 * reach)) - reach;
    if (p < 0) p = 0;
    if (p > limit) p = limit;
    return p;
  endfunction

  function automatic logic [CfgDataW-1:0] random_coord(int lo, int hi);
    if ($urandom_range(0, 3) == 0) return CfgDataW'($urandom_range(0, 65535));
    return CfgDataW'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  task automatic send_pixel(logic [RowW-1:0] row, logic [ColW-1:0] col);
    int unsigned k;
    rgb_t c;
    if (!calm && $urandom_range(0, 4) == 0) begin
      pix.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    pix.valid     <= 1'b1;
    pix.pixel_row <= row;
    pix.pixel_col <= col;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    k = covered_samples(row, col);
    c.red   = RedW'((127 * k) / 25);
    c.green = GreenW'((127 * k) / 25);
    c.blue  = BlueW'((255 * k) / 25);
    pending_colors = {pending_colors, c};
    levels_seen[k] = 1'b1;
    pixels_sent++;
  endtask

  task automatic drain_pipeline();
    pix.valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      RegBody0X:     disc_x[0] = data;
      RegBody0Y:     disc_y[0] = data;
      RegBody1X:     disc_x[1] = data;
      RegBody1Y:     disc_y[1] = data;
      RegBody2X:     disc_x[2] = data;
      RegBody2Y:     disc_y[2] = data;
      RegDiscRadius: disc_r = data[RadW-1:0];
      default: ;
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic set_discs(logic [CfgDataW-1:0] vals [NumRegs]);
    drain_pipeline();
    for (int i = 0; i < NumRegs; i++) write_reg(CfgIdxW'(i), vals[i]);
    close_writes();
  endtask

  task automatic test_default_discs();
    send_pixel(10'd342, 9'd260);
    send_pixel(10'd298, 9'd240);
    send_pixel(10'd320, 9'd208);
    send_pixel(10'd345, 9'd260);
    send_pixel(10'd342, 9'd263);
    send_pixel(10'd0, 9'd0);
    send_pixel(10'd1023, 9'd511);
    send_pixel(10'd639, 9'd479);
    send_pixel(10'd640, 9'd480);
    send_pixel(10'd0, 9'd511);
    send_pixel(10'd1023, 9'd0);
  endtask

  // Radius write with bit 15 set lands as zero; the unused index is ignored.
  task automatic test_zero_radius();
    drain_pipeline();
    write_reg(RegDiscRadius, 16'h8000);
    write_reg(RegUnused, 16'hFFFF);
    close_writes();
    send_pixel(10'd342, 9'd260);
    send_pixel(10'd298, 9'd240);
    send_pixel(10'd320, 9'd208);
    drain_pipeline();
    write_reg(RegDiscRadius, 16'd120);
    write_reg(RegUnused, 16'h0000);
    close_writes();
    send_pixel(10'd342, 9'd260);
    send_pixel(10'd320, 9'd208);
  endtask

  task automatic test_extreme_discs();
    set_discs('{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h7FFF});
    send_pixel(10'd0, 9'd0);
    send_pixel(10'd1023, 9'd511);
    send_pixel(10'd0, 9'd511);
    send_pixel(10'd1023, 9'd0);
    send_pixel(10'd320, 9'd240);
    send_pixel(10'd1023, 9'd240);
  endtask

  task automatic random_discs();
    logic [CfgDataW-1:0] vals [NumRegs];
    for (int b = 0; b < NumBodies; b++) begin
      vals[2 * b]     = random_coord(-12800, 27000);
      vals[2 * b + 1] = random_coord(-9600, 10800);
    end
    case ($urandom_range(0, 9))
      0:       vals[6] = CfgDataW'($urandom_range(0, 32767));
      1:       vals[6] = CfgDataW'(16'h8000 | $urandom_range(0, 400));
      default: vals[6] = CfgDataW'($urandom_range(0, 400));
    endcase
    set_discs(vals);
  endtask

  task automatic random_pixels(int unsigned count);
    int unsigned b;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) begin
        row = RowW'($urandom_range(0, 1023));
        col = ColW'($urandom_range(0, 511));
      end else begin
        b = $urandom_range(0, NumBodies - 1);
        row = RowW'(aim_at(longint'(disc_x[b]), longint'(ImageRows / 2), 1023));
        col = ColW'(aim_at(longint'(disc_y[b]), longint'(ImageCols / 2), 511));
      end
      send_pixel(row, col);
    end
  endtask

  task automatic test_random_discs();
    for (int p = 0; p < RandomPhases; p++) begin
      random_discs();
      random_pixels(PhaseItems);
    end
  endtask

  task automatic test_full_rate();
    random_discs();
    calm = 1'b1;
    random_pixels(FullRateItems);
  endtask

  // Hold ready low in random bursts until the full-rate stretch.
  initial begin
    rgb.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 6) == 0) begin
        rgb.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      rgb.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && ((pix.valid && pix.ready) || (rgb.valid && rgb.ready))) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout after %0d cycles without a transfer", idle_cycles);
      $display("status: fail");
      $finish;
    end
    if (rst_ni && rgb.valid && rgb.ready) begin
      if (pending_colors.size() == 0) begin
        if (color_mismatches < MaxReports)
          $display("unexpected color r=%0d g=%0d b=%0d", rgb.red, rgb.green, rgb.blue);
        color_mismatches++;
      end else begin
        want = pending_colors.pop_front();
        colors_checked++;
        if (rgb.red !== want.red || rgb.green !== want.green || rgb.blue !== want.blue) begin
          if (color_mismatches < MaxReports)
            $display("color %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     colors_checked, want.red, want.green, want.blue,
                     rgb.red, rgb.green, rgb.blue);
          color_mismatches++;
        end
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    pix.valid        <= 1'b0;
    pix.pixel_row    <= '0;
    pix.pixel_col    <= '0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= RegBody0X;
    cfg_data_i       <= '0;
    disc_x[0]        = Body0XRst;
    disc_y[0]        = Body0YRst;
    disc_x[1]        = Body1XRst;
    disc_y[1]        = Body1YRst;
    disc_x[2]        = Body2XRst;
    disc_y[2]        = Body2YRst;
    disc_r           = RadiusRst;
    pixels_sent      = 0;
    colors_checked   = 0;
    color_mismatches = 0;
    idle_cycles      = 0;
    settings_used    = 1;
    levels_seen      = '0;
    calm             = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_default_discs();
    test_zero_radius();
    test_extreme_discs();
    test_random_discs();
    test_full_rate();

    drain_pipeline();
    repeat (LatencyCycles) @(posedge clk_i);
    $display("%0d pixels shaded under %0d disc settings, %0d colors checked",
             pixels_sent, settings_used, colors_checked);
    $display("%0d of %0d coverage levels reached", $countones(levels_seen), NumSamples + 1);
    if (color_mismatches == 0 && pending_colors.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d colors missing", color_mismatches, pending_colors.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
